FILE: rtl/core/lpsq_pkg.sv
// ----------------------------------------------------------------------------
// lpsq_pkg
// Shared types and constants for the LED panel init and row sequencer.
// ----------------------------------------------------------------------------
package lpsq_pkg;

  localparam int ROW_BITS  = 5;
  localparam int NUM_WORDS = 5;
  localparam int WORD_W    = 16;
  localparam int CPB_W     = 4;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_PINS  = 6;

  localparam logic [4:0] BURST_A      = 5'd3;
  localparam logic [4:0] BURST_B      = 5'd11;
  localparam logic [4:0] BURST_C      = 5'd14;
  localparam logic [4:0] TRAIL_CLOCKS = 5'd8;
  localparam logic [4:0] VSYNC_PULSES = 5'd3;
  localparam logic [4:0] SINGLE_PULSE = 5'd1;

  localparam logic [CPB_W-1:0] DEFAULT_CPB = 4'd5;

  localparam logic [WORD_W-1:0] WORD_ONE_RST   = 16'h00AA;
  localparam logic [WORD_W-1:0] WORD_TWO_RST   = 16'h01AA;
  localparam logic [WORD_W-1:0] WORD_THREE_RST = 16'h0000;
  localparam logic [WORD_W-1:0] WORD_FOUR_RST  = 16'hF003;
  localparam logic [WORD_W-1:0] WORD_FIVE_RST  = 16'h0055;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INIT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ROW    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VSYNC  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_FIVE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CPB        = 3'd5;

  // bit positions in the pin vector
  localparam int PIN_LAT   = 0;
  localparam int PIN_DCLK  = 1;
  localparam int PIN_RGB   = 2;
  localparam int PIN_RDATA = 3;
  localparam int PIN_RCLK  = 4;
  localparam int PIN_RLAT  = 5;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LAT1   = 4'd1,
    PH_CLK1   = 4'd2,
    PH_LAT2   = 4'd3,
    PH_CLK2   = 4'd4,
    PH_LAT3   = 4'd5,
    PH_CLK3   = 4'd6,
    PH_WORDS  = 4'd7,
    PH_CLK4   = 4'd8,
    PH_RSHIFT = 4'd9,
    PH_RLATCH = 4'd10,
    PH_VLAT   = 4'd11
  } phase_t;

  typedef logic [WORD_W-1:0] word_arr_t [NUM_WORDS];

  typedef struct packed {
    phase_t                phase;
    logic [4:0]            pulses_left;
    logic [3:0]            bit_index;
    logic [3:0]            clock_index;
    logic [2:0]            word_index;
    logic [ROW_BITS-1:0]   row_shift;
    logic                  half_period;
    logic [NUM_PINS-1:0]   pins;
  } seq_state_t;

endpackage

FILE: rtl/core/lpsq_step.sv
// ----------------------------------------------------------------------------
// lpsq_step
// Next-state logic: applies one beat (command or tick) to the sequencer state.
// ----------------------------------------------------------------------------
module lpsq_step (
  input  lpsq_pkg::seq_state_t              st,
  input  logic [lpsq_pkg::KIND_W-1:0]       kind,
  input  logic [lpsq_pkg::ROW_BITS-1:0]     row_address,
  input  lpsq_pkg::word_arr_t               words,
  input  logic [lpsq_pkg::CPB_W-1:0]        cfg_cpb,
  output lpsq_pkg::seq_state_t              st_nxt,
  output logic                              accepted
);
  import lpsq_pkg::*;

  function automatic seq_state_t enter_ph(seq_state_t s_in, phase_t ph);
    seq_state_t s;
    s = s_in;
    s.phase = ph;
    s.half_period = 1'b0;
    unique case (ph) inside
      PH_LAT1: s.pulses_left = BURST_A;
      PH_LAT2: s.pulses_left = BURST_B;
      PH_LAT3: s.pulses_left = BURST_C;
      PH_CLK1, PH_CLK2, PH_CLK3, PH_CLK4: s.pulses_left = TRAIL_CLOCKS;
      PH_WORDS: begin
        s.word_index  = 3'd0;
        s.bit_index   = 4'd15;
        s.clock_index = 4'd0;
      end
      PH_RSHIFT: s.bit_index = 4'(ROW_BITS - 1);
      default: ;
    endcase
    return s;
  endfunction

  function automatic phase_t after_ph(phase_t ph);
    phase_t n;
    unique case (ph)
      PH_LAT1:   n = PH_CLK1;
      PH_CLK1:   n = PH_LAT2;
      PH_LAT2:   n = PH_CLK2;
      PH_CLK2:   n = PH_LAT3;
      PH_LAT3:   n = PH_CLK3;
      PH_CLK3:   n = PH_WORDS;
      PH_WORDS:  n = PH_CLK4;
      PH_RSHIFT: n = PH_RLATCH;
      default:   n = PH_IDLE;
    endcase
    return n;
  endfunction

  seq_state_t       s;
  logic [CPB_W-1:0] cpb;
  logic [CPB_W-1:0] ci;
  logic [4:0]       pl;
  logic [2:0]       wsel;
  logic [WORD_W-1:0] w;
  logic [7:0]       row_ext;

  assign cpb     = (cfg_cpb == '0) ? CPB_W'(1) : cfg_cpb;
  assign wsel    = (st.word_index < 3'(NUM_WORDS)) ? st.word_index : 3'd0;
  assign w       = words[wsel];
  assign row_ext = 8'(st.row_shift);

  always_comb begin
    s        = st;
    accepted = 1'b0;
    ci       = st.clock_index + 4'd1;
    pl       = st.pulses_left - ((st.pulses_left != 5'd0) ? 5'd1 : 5'd0);

    if (kind == KIND_TICK) begin
      unique case (st.phase) inside
        PH_LAT1, PH_LAT2, PH_LAT3, PH_VLAT,
        PH_CLK1, PH_CLK2, PH_CLK3, PH_CLK4: begin
          if (!st.half_period) begin
            if (st.phase == PH_LAT1 || st.phase == PH_LAT2 ||
                st.phase == PH_LAT3 || st.phase == PH_VLAT) begin
              s.pins[PIN_LAT] = 1'b1;
            end else begin
              s.pins[PIN_DCLK] = 1'b1;
            end
            s.half_period = 1'b1;
          end else begin
            if (st.phase == PH_LAT1 || st.phase == PH_LAT2 ||
                st.phase == PH_LAT3 || st.phase == PH_VLAT) begin
              s.pins[PIN_LAT] = 1'b0;
            end else begin
              s.pins[PIN_DCLK] = 1'b0;
            end
            s.half_period = 1'b0;
            s.pulses_left = pl;
            if (pl == 5'd0) begin
              s = enter_ph(s, after_ph(st.phase));
            end
          end
        end
        PH_WORDS: begin
          if (!st.half_period) begin
            s.pins[PIN_RGB]  = w[st.bit_index];
            s.pins[PIN_DCLK] = 1'b1;
            s.half_period    = 1'b1;
          end else begin
            s.pins[PIN_DCLK] = 1'b0;
            s.half_period    = 1'b0;
            s.clock_index    = ci;
            if (ci >= cpb) begin
              s.clock_index = 4'd0;
              if (st.bit_index == 4'd0) begin
                s.bit_index  = 4'd15;
                s.word_index = st.word_index + 3'd1;
                if (s.word_index >= 3'(NUM_WORDS)) begin
                  s = enter_ph(s, PH_CLK4);
                end
              end else begin
                s.bit_index = st.bit_index - 4'd1;
              end
            end
          end
        end
        PH_RSHIFT: begin
          if (!st.half_period) begin
            s.pins[PIN_RDATA] = row_ext[st.bit_index[2:0]];
            s.pins[PIN_RCLK]  = 1'b1;
            s.half_period     = 1'b1;
          end else begin
            s.pins[PIN_RCLK] = 1'b0;
            s.half_period    = 1'b0;
            if (st.bit_index == 4'd0) begin
              s = enter_ph(s, PH_RLATCH);
            end else begin
              s.bit_index = st.bit_index - 4'd1;
            end
          end
        end
        PH_RLATCH: begin
          if (!st.half_period) begin
            s.pins[PIN_RLAT] = 1'b1;
            s.half_period    = 1'b1;
          end else begin
            s.pins[PIN_RLAT] = 1'b0;
            s = enter_ph(s, PH_IDLE);
          end
        end
        default: s.phase = PH_IDLE;
      endcase
    end else if (st.phase == PH_IDLE) begin
      unique case (kind) inside
        KIND_INIT: begin
          accepted = 1'b1;
          s = enter_ph(s, PH_LAT1);
        end
        KIND_ROW: begin
          accepted    = 1'b1;
          s.row_shift = row_address;
          s = enter_ph(s, PH_RSHIFT);
        end
        KIND_VSYNC, KIND_SINGLE: begin
          accepted = 1'b1;
          s = enter_ph(s, PH_VLAT);
          s.pulses_left = (kind == KIND_VSYNC) ? VSYNC_PULSES : SINGLE_PULSE;
        end
        default: ;
      endcase
    end
  end

  assign st_nxt = s;

endmodule

FILE: rtl/core/led_panel_init_and_row_sequencer_core.sv
// ----------------------------------------------------------------------------
// led_panel_init_and_row_sequencer_core
// Tick-driven pin sequencer: driver init shift, row address latch, vsync.
// ----------------------------------------------------------------------------
// Each input beat is either a command (init, row latch, vsync, single latch)
// or a tick; a tick advances the running sequence by one half-period. Every
// beat produces one result beat with all six pin levels, busy and accepted.
// One beat is taken per clock: the sequence state updates in the cycle the
// beat is accepted and the result sits in the output register, so a new beat
// is accepted whenever that register is empty or being drained. Commands that
// arrive while busy are dropped with accepted low. Configuration words and
// clocks-per-bit are written through cfg_* and take effect immediately.
module led_panel_init_and_row_sequencer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lpsq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpsq_pkg::WORD_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lpsq_pkg::KIND_W-1:0]         in_kind,
  input  logic [lpsq_pkg::ROW_BITS-1:0]       in_row_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_lat_pin,
  output logic                                out_dclk_pin,
  output logic                                out_rgb_data_pin,
  output logic                                out_row_data_pin,
  output logic                                out_row_clk_pin,
  output logic                                out_row_lat_pin,
  output logic                                out_busy_res,
  output logic                                out_accepted
);
  import lpsq_pkg::*;

  word_arr_t        words_r;
  logic [CPB_W-1:0] cpb_r;
  seq_state_t       state_r;
  seq_state_t       state_nxt;
  logic             acc_nxt;
  logic             acc_r;
  logic             out_valid_r;
  logic             in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  lpsq_step u_step (
    .st          (state_r),
    .kind        (in_kind),
    .row_address (in_row_address),
    .words       (words_r),
    .cfg_cpb     (cpb_r),
    .st_nxt      (state_nxt),
    .accepted    (acc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r[0] <= WORD_ONE_RST;
      words_r[1] <= WORD_TWO_RST;
      words_r[2] <= WORD_THREE_RST;
      words_r[3] <= WORD_FOUR_RST;
      words_r[4] <= WORD_FIVE_RST;
      cpb_r      <= DEFAULT_CPB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WORD_ONE:   words_r[0] <= cfg_wdata;
        CFG_WORD_TWO:   words_r[1] <= cfg_wdata;
        CFG_WORD_THREE: words_r[2] <= cfg_wdata;
        CFG_WORD_FOUR:  words_r[3] <= cfg_wdata;
        CFG_WORD_FIVE:  words_r[4] <= cfg_wdata;
        CFG_CPB:        cpb_r      <= cfg_wdata[CPB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{phase: PH_IDLE, default: '0};
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lat_pin      = state_r.pins[PIN_LAT];
  assign out_dclk_pin     = state_r.pins[PIN_DCLK];
  assign out_rgb_data_pin = state_r.pins[PIN_RGB];
  assign out_row_data_pin = state_r.pins[PIN_RDATA];
  assign out_row_clk_pin  = state_r.pins[PIN_RCLK];
  assign out_row_lat_pin  = state_r.pins[PIN_RLAT];
  assign out_busy_res     = (state_r.phase != PH_IDLE);
  assign out_accepted     = acc_r;

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && acc_r |-> out_busy_res)
    else $error("accepted command without busy");

  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && state_r.phase == PH_IDLE &&
    (in_kind == KIND_INIT || in_kind == KIND_ROW ||
     in_kind == KIND_VSYNC || in_kind == KIND_SINGLE)
    |=> state_r.phase != PH_IDLE && acc_r)
    else $error("command from idle did not start a sequence");

  a_idle_half: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_IDLE |-> !state_r.half_period)
    else $error("idle with half period set");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && state_r.phase == PH_IDLE && in_kind == KIND_TICK
    |=> $stable(state_r.pins) && !acc_r)
    else $error("idle tick changed pins");

  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.word_index <= 3'(NUM_WORDS))
    else $error("word index out of range");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED panel init and row sequencer core.
// A directed table walks reset behavior, every command kind, unknown kinds
// and commands that hit a busy sequencer. Random traffic then runs mostly
// well-formed command/tick runs over several register settings: extreme
// words, zero and maximum clocks per bit, and writes to unused indexes.
// Some writes land while a sequence is still running. Each output beat is
// checked bit by bit against a typed table frame or an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
  import lpsq_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 246;
  localparam int NUM_PHASES  = 8;
  localparam int GAP_PCT     = 19;
  localparam int NUM_DIRECTED = 28;

  localparam logic [KIND_W-1:0]    KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_UNUSED_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST   = 3'd7;

  typedef struct packed {
    logic                accepted;
    logic                busy;
    logic [NUM_PINS-1:0] pins;
  } pin_frame_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ROW_BITS-1:0] row;
    logic                typed;
    pin_frame_t          frame;
  } stim_row_t;

  localparam pin_frame_t FR_IDLE  = '0;
  localparam pin_frame_t FR_ARMED = '{accepted: 1'b1, busy: 1'b1, pins: '0};
  localparam pin_frame_t FR_HELD  = '{accepted: 1'b0, busy: 1'b1, pins: '0};
  localparam pin_frame_t FR_LAT   = '{accepted: 1'b0, busy: 1'b1,
                                      pins: NUM_PINS'(1 << PIN_LAT)};

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [WORD_W-1:0]    cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic [KIND_W-1:0]    in_kind        = '0;
  logic [ROW_BITS-1:0]  in_row_address = '0;
  logic                 out_ready      = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_lat_pin;
  logic                 out_dclk_pin;
  logic                 out_rgb_data_pin;
  logic                 out_row_data_pin;
  logic                 out_row_clk_pin;
  logic                 out_row_lat_pin;
  logic                 out_busy_res;
  logic                 out_accepted;

  led_panel_init_and_row_sequencer_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_row_address   (in_row_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_lat_pin      (out_lat_pin),
    .out_dclk_pin     (out_dclk_pin),
    .out_rgb_data_pin (out_rgb_data_pin),
    .out_row_data_pin (out_row_data_pin),
    .out_row_clk_pin  (out_row_clk_pin),
    .out_row_lat_pin  (out_row_lat_pin),
    .out_busy_res     (out_busy_res),
    .out_accepted     (out_accepted)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // sequencer model state
  phase_t              sq_phase;
  logic [4:0]          sq_left;
  logic [3:0]          sq_bit;
  logic [3:0]          sq_clk;
  logic [2:0]          sq_word;
  logic [ROW_BITS-1:0] sq_row;
  logic                sq_half;
  logic [NUM_PINS-1:0] sq_pins;
  logic [WORD_W-1:0]   shadow_words [NUM_WORDS];
  logic [CPB_W-1:0]    shadow_cpb;

  pin_frame_t frames_due [$];
  int         mismatches  = 0;
  int         idle_cycles = 0;
  bit         gaps_on     = 1'b1;

  string field_names [8] = '{"lat_pin", "dclk_pin", "rgb_data_pin", "row_data_pin",
                             "row_clk_pin", "row_lat_pin", "busy_res", "accepted"};

  function automatic phase_t phase_after(input phase_t p);
    case (p)
      PH_LAT1:   return PH_CLK1;
      PH_CLK1:   return PH_LAT2;
      PH_LAT2:   return PH_CLK2;
      PH_CLK2:   return PH_LAT3;
      PH_LAT3:   return PH_CLK3;
      PH_CLK3:   return PH_WORDS;
      PH_WORDS:  return PH_CLK4;
      PH_RSHIFT: return PH_RLATCH;
      default:   return PH_IDLE;
    endcase
  endfunction

  task automatic enter_phase(input phase_t p);
    sq_phase = p;
    sq_half  = 1'b0;
    case (p)
      PH_LAT1: sq_left = BURST_A;
      PH_LAT2: sq_left = BURST_B;
      PH_LAT3: sq_left = BURST_C;
      PH_CLK1, PH_CLK2, PH_CLK3, PH_CLK4: sq_left = TRAIL_CLOCKS;
      PH_WORDS: begin
        sq_word = '0;
        sq_bit  = 4'(WORD_W - 1);
        sq_clk  = '0;
      end
      PH_RSHIFT: sq_bit = 4'(ROW_BITS - 1);
      default: ;
    endcase
  endtask

  task automatic pulse_pin(input int pin);
    if (!sq_half) begin
      sq_pins[pin] = 1'b1;
      sq_half      = 1'b1;
    end else begin
      sq_pins[pin] = 1'b0;
      sq_half      = 1'b0;
      if (sq_left != 0) sq_left--;
      if (sq_left == 0) enter_phase(phase_after(sq_phase));
    end
  endtask

  // one half-period of the running sequence
  task automatic advance_pins();
    logic [CPB_W-1:0]  cpb_eff;
    logic [WORD_W-1:0] w;
    int                wi;
    cpb_eff = (shadow_cpb == '0) ? CPB_W'(1) : shadow_cpb;
    case (sq_phase)
      PH_LAT1, PH_LAT2, PH_LAT3, PH_VLAT: pulse_pin(PIN_LAT);
      PH_CLK1, PH_CLK2, PH_CLK3, PH_CLK4: pulse_pin(PIN_DCLK);
      PH_WORDS: begin
        if (!sq_half) begin
          wi = (sq_word < NUM_WORDS) ? int'(sq_word) : 0;
          w  = shadow_words[wi];
          sq_pins[PIN_RGB]  = w[sq_bit];
          sq_pins[PIN_DCLK] = 1'b1;
          sq_half           = 1'b1;
        end else begin
          sq_pins[PIN_DCLK] = 1'b0;
          sq_half           = 1'b0;
          sq_clk            = sq_clk + 1'b1;
          if (sq_clk >= cpb_eff) begin
            sq_clk = '0;
            if (sq_bit == 0) begin
              sq_bit = 4'(WORD_W - 1);
              sq_word++;
              if (sq_word >= NUM_WORDS) enter_phase(PH_CLK4);
            end else begin
              sq_bit--;
            end
          end
        end
      end
      PH_RSHIFT: begin
        if (!sq_half) begin
          sq_pins[PIN_RDATA] = sq_row[sq_bit];
          sq_pins[PIN_RCLK]  = 1'b1;
          sq_half            = 1'b1;
        end else begin
          sq_pins[PIN_RCLK] = 1'b0;
          sq_half           = 1'b0;
          if (sq_bit == 0) enter_phase(PH_RLATCH);
          else sq_bit--;
        end
      end
      PH_RLATCH: begin
        if (!sq_half) begin
          sq_pins[PIN_RLAT] = 1'b1;
          sq_half           = 1'b1;
        end else begin
          sq_pins[PIN_RLAT] = 1'b0;
          enter_phase(PH_IDLE);
        end
      end
      default: sq_phase = PH_IDLE;
    endcase
  endtask

  task automatic panel_step(input logic [KIND_W-1:0] k, input logic [ROW_BITS-1:0] r,
                            output pin_frame_t f);
    logic took;
    took = 1'b0;
    if (k == KIND_TICK) begin
      if (sq_phase != PH_IDLE) advance_pins();
    end else if (k <= KIND_SINGLE && sq_phase == PH_IDLE) begin
      took = 1'b1;
      case (k)
        KIND_INIT: enter_phase(PH_LAT1);
        KIND_ROW: begin
          sq_row = r;
          enter_phase(PH_RSHIFT);
        end
        default: begin
          enter_phase(PH_VLAT);
          sq_left = (k == KIND_VSYNC) ? VSYNC_PULSES : SINGLE_PULSE;
        end
      endcase
    end
    f.accepted = took;
    f.busy     = (sq_phase != PH_IDLE);
    f.pins     = sq_pins;
  endtask

  task automatic send_beat(input logic [KIND_W-1:0] k, input logic [ROW_BITS-1:0] r,
                           input logic typed, input pin_frame_t typed_frame);
    pin_frame_t f;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < GAP_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_row_address <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    panel_step(k, r, f);
    frames_due.push_back(typed ? typed_frame : f);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < NUM_WORDS) shadow_words[idx] = data;
    else if (idx == CFG_CPB) shadow_cpb = data[CPB_W-1:0];
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : drain_results
    pin_frame_t got;
    pin_frame_t want;
    logic [7:0] gv;
    logic [7:0] wv;
    if (rst_n && out_valid && out_ready) begin
      got = {out_accepted, out_busy_res, out_row_lat_pin, out_row_clk_pin,
             out_row_data_pin, out_rgb_data_pin, out_dclk_pin, out_lat_pin};
      if (frames_due.size() == 0) begin
        mismatches++;
        $display("%0t: beat with nothing expected, got %b", $time, got);
      end else begin
        want = frames_due.pop_front();
        gv   = got;
        wv   = want;
        for (int i = 0; i < 8; i++) begin
          if (gv[i] !== wv[i]) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %b, got %b",
                     $time, field_names[i], wv[i], gv[i]);
          end
        end
      end
    end
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= GAP_PCT) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    stim_row_t            directed [NUM_DIRECTED];
    logic [CFG_IDX_W-1:0] word_regs [NUM_WORDS];
    logic [CPB_W-1:0]     cpb_plan [NUM_PHASES];
    logic [KIND_W-1:0]    k;
    logic [WORD_W-1:0]    w;
    int                   roll;

    directed = '{
      '{KIND_TICK,         5'd0,  1'b1, FR_IDLE},
      '{KIND_UNUSED_FIRST, 5'd31, 1'b1, FR_IDLE},
      '{KIND_SINGLE,       5'd0,  1'b1, FR_ARMED},
      '{KIND_INIT,         5'd0,  1'b1, FR_HELD},
      '{KIND_UNUSED_LAST,  5'd0,  1'b1, FR_HELD},
      '{KIND_TICK,         5'd0,  1'b1, FR_LAT},
      '{KIND_TICK,         5'd0,  1'b1, FR_IDLE},
      '{KIND_ROW,          5'd31, 1'b1, FR_ARMED},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_VSYNC,        5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_TICK,         5'd0,  1'b0, FR_IDLE},
      '{KIND_INIT,         5'd0,  1'b0, FR_IDLE}
    };
    word_regs = '{CFG_WORD_ONE, CFG_WORD_TWO, CFG_WORD_THREE, CFG_WORD_FOUR, CFG_WORD_FIVE};
    cpb_plan  = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd1, 4'd3, 4'd1, 4'd4};

    shadow_words = '{WORD_ONE_RST, WORD_TWO_RST, WORD_THREE_RST, WORD_FOUR_RST, WORD_FIVE_RST};
    shadow_cpb   = DEFAULT_CPB;
    sq_phase     = PH_IDLE;
    sq_left      = '0;
    sq_bit       = '0;
    sq_clk       = '0;
    sq_word      = '0;
    sq_row       = '0;
    sq_half      = 1'b0;
    sq_pins      = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_beat(directed[i].kind, directed[i].row, directed[i].typed, directed[i].frame);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_outputs();
      gaps_on = (p != 3);
      // a sequence may still be mid-run here; new values apply at once
      for (int n = 0; n < NUM_WORDS; n++) begin
        if (p == 0) w = '1;
        else if (p == 1) w = '0;
        else begin
          case ($urandom_range(0, 3))
            0:       w = '0;
            1:       w = '1;
            default: w = WORD_W'($urandom);
          endcase
        end
        cfg_write(word_regs[n], w);
      end
      cfg_write(CFG_CPB, {12'($urandom), cpb_plan[p]});
      cfg_write(p[0] ? CFG_UNUSED_FIRST : CFG_UNUSED_LAST, WORD_W'($urandom));
      cfg_we <= 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (sq_phase == PH_IDLE) begin
          if (roll < 8) begin
            k = KIND_TICK;
          end else if (roll < 14) begin
            k = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
          end else begin
            k = KIND_W'($urandom_range(KIND_INIT, KIND_SINGLE));
            // long inits at slow bit rates only now and then
            if (k == KIND_INIT && shadow_cpb > 3 && $urandom_range(0, 3) != 0)
              k = KIND_W'($urandom_range(KIND_ROW, KIND_SINGLE));
          end
        end else begin
          if (roll < 88) k = KIND_TICK;
          else if (roll < 94) k = KIND_W'($urandom_range(KIND_INIT, KIND_SINGLE));
          else k = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        end
        send_beat(k, ROW_BITS'($urandom_range(0, 31)), 1'b0, FR_IDLE);
      end
    end

    settle_outputs();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: led_panel_init_and_row_sequencer_core.f
rtl/core/lpsq_pkg.sv
rtl/core/lpsq_step.sv
rtl/core/led_panel_init_and_row_sequencer_core.sv
test/tb_top.sv
